FILE: design/mtt_pkg.sv
package mtt_pkg;

    localparam int OFFSET_BITS = 32;

    localparam int TDATA_IN_W  = 8;
    localparam int TDATA_OUT_W = 72;
    localparam int MAX_TOK     = 3;
    localparam int FIFO_DEPTH  = 4;
    localparam int PTR_W       = $clog2(FIFO_DEPTH);
    localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);

    typedef logic [OFFSET_BITS-1:0] off_t;
    localparam off_t OFF_ONE = off_t'(1);

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_BANG  = 8'h21;

    localparam logic [3:0] PROLOG_LAST = 4'd8;
    localparam logic [3:0] PROLOG_LEN  = 4'd9;
    localparam logic [3:0] PROLOG_DONE = 4'd15;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_LT,
        MODE_NAME,
        MODE_NAME_SLASH,
        MODE_SLASH,
        MODE_STRING
    } mode_t;

    typedef enum logic [2:0] {
        KIND_UNKNOWN,
        KIND_OPEN,
        KIND_CLOSE,
        KIND_EQUALS,
        KIND_STRING,
        KIND_EOS
    } kind_t;

    typedef struct packed {
        logic [31:0] len;
        logic [31:0] start;
        kind_t       kind;
    } token_t;

    typedef struct packed {
        logic [1:0]           n;
        token_t [MAX_TOK-1:0] t;
    } tok_buf_t;

    typedef struct packed {
        logic   last;
        token_t tok;
    } entry_t;

    function automatic logic [31:0] off_to32(off_t v);
        logic [OFFSET_BITS+31:0] w;
        w = {32'd0, v};
        return w[31:0];
    endfunction

    function automatic tok_buf_t add_tok(tok_buf_t bi, kind_t kind, off_t start, off_t len);
        tok_buf_t bo;
        bo = bi;
        if (bi.n != 2'(MAX_TOK)) begin
            bo.t[bi.n].kind  = kind;
            bo.t[bi.n].start = off_to32(start);
            bo.t[bi.n].len   = off_to32(len);
            bo.n             = bi.n + 2'd1;
        end
        return bo;
    endfunction

    function automatic logic is_space(logic [7:0] b);
        return b == 8'h20 || b == 8'h09 || b == 8'h0A || b == 8'h0B ||
               b == 8'h0C || b == 8'h0D;
    endfunction

    function automatic logic [7:0] prolog_char(logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0: c = CH_LT;
            4'd1: c = CH_BANG;
            4'd2: c = 8'h44;
            4'd3: c = 8'h4F;
            4'd4: c = 8'h43;
            4'd5: c = 8'h54;
            4'd6: c = 8'h59;
            4'd7: c = 8'h50;
            4'd8: c = 8'h45;
            default: c = CH_NUL;
        endcase
        return c;
    endfunction

endpackage

FILE: design/markup_tag_tokenizer_top.sv
// Channel  | Dir | tdata (low bit up)                             | tlast
// s_axis   | in  | in_byte[7:0]                                   | final_byte
// m_axis   | out | token_kind[2:0], token_start[34:3],            | run_end
//          |     | token_length[66:35], zero[71:67]               |
//
// One byte is scanned per cycle: the scan logic turns a byte and the scan
// state into up to three tokens, written at once into a four-entry result
// queue. Tokens leave one per cycle while m_tready is high, so bytes that
// give one token or none stream at one per cycle; a byte that gives two or
// three tokens holds s_tready low until the queue has room for three again.
// Reset (aresetn low, synchronous) empties the queue and returns the scanner
// to document start; the final byte resets the scanner as its tokens queue.
module markup_tag_tokenizer_top import mtt_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [TDATA_IN_W-1:0]  s_tdata,   // in_byte[7:0]
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_OUT_W-1:0] m_tdata,   // token_kind, token_start, token_length
    output logic                   m_tlast
);

    mode_t      mode_reg, mode_next;
    off_t       pos_reg, pos_next;
    off_t       pstart_reg, pstart_next;
    logic       pclose_reg, pclose_next;
    logic [3:0] pcnt_reg, pcnt_next;
    logic       pskip_reg, pskip_next;

    entry_t            fifo_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    tok_buf_t   tb;
    logic       accept, pop;

    always_comb begin
        logic [7:0] b;
        off_t       pos1;
        logic       done;
        logic       do_scan;
        b           = s_tdata[7:0];
        pos1        = pos_reg + OFF_ONE;
        mode_next   = mode_reg;
        pstart_next = pstart_reg;
        pclose_next = pclose_reg;
        pcnt_next   = pcnt_reg;
        pskip_next  = pskip_reg;
        tb          = '0;
        do_scan     = !pskip_reg || b == CH_NUL || b == CH_LT;
        if (pskip_reg && do_scan) begin
            pskip_next = 1'b0;
            mode_next  = MODE_IDLE;
        end
        done = !do_scan;
        for (int p = 0; p < 2; p++) begin
            if (!done) begin
                done = 1'b1;
                case (mode_next)
                    MODE_LT: begin
                        mode_next = MODE_NAME;
                        if (b == CH_SLASH) begin
                            pclose_next = 1'b1;
                            pstart_next = pos1;
                        end else begin
                            pclose_next = 1'b0;
                            pstart_next = pos_reg;
                            done        = 1'b0;
                        end
                    end
                    MODE_NAME: begin
                        if (is_space(b) || b == CH_GT || b == CH_SLASH) begin
                            tb = add_tok(tb, pclose_next ? KIND_CLOSE : KIND_OPEN,
                                         pstart_next, pos_reg - pstart_next);
                            if (b == CH_SLASH) begin
                                pstart_next = pos_reg;
                                mode_next   = MODE_NAME_SLASH;
                            end else begin
                                mode_next = MODE_IDLE;
                            end
                        end
                    end
                    MODE_NAME_SLASH: begin
                        mode_next = MODE_IDLE;
                        if (b != CH_GT) begin
                            tb   = add_tok(tb, KIND_UNKNOWN, pstart_next, OFF_ONE);
                            done = 1'b0;
                        end
                    end
                    MODE_SLASH: begin
                        mode_next = MODE_IDLE;
                        if (b == CH_GT) begin
                            tb = add_tok(tb, KIND_CLOSE, pstart_next, OFF_ONE);
                        end else begin
                            tb   = add_tok(tb, KIND_UNKNOWN, pstart_next, OFF_ONE);
                            done = 1'b0;
                        end
                    end
                    MODE_STRING: begin
                        if (b == CH_QUOTE || b == CH_NUL || b == CH_EQ || b == CH_LT) begin
                            tb = add_tok(tb, KIND_STRING, pstart_next, pos_reg - pstart_next);
                            mode_next = MODE_IDLE;
                            done      = (b == CH_QUOTE);
                        end
                    end
                    default: begin
                        mode_next = MODE_IDLE;
                        if (is_space(b)) begin
                            mode_next = MODE_IDLE;
                        end else if (b == CH_NUL) begin
                            tb = add_tok(tb, KIND_EOS, pos_reg, OFF_ONE);
                        end else if (b == CH_EQ) begin
                            tb = add_tok(tb, KIND_EQUALS, pos_reg, OFF_ONE);
                        end else if (b == CH_LT) begin
                            pstart_next = pos_reg;
                            mode_next   = MODE_LT;
                        end else if (b == CH_SLASH) begin
                            pstart_next = pos_reg;
                            mode_next   = MODE_SLASH;
                        end else begin
                            pstart_next = (b == CH_QUOTE) ? pos1 : pos_reg;
                            mode_next   = MODE_STRING;
                        end
                    end
                endcase
            end
        end
        if (!pskip_reg && pcnt_reg < PROLOG_LEN) begin
            if (b == prolog_char(pcnt_reg)) begin
                if (pcnt_reg == PROLOG_LAST) begin
                    pcnt_next  = PROLOG_DONE;
                    pskip_next = 1'b1;
                    mode_next  = MODE_IDLE;
                end else begin
                    pcnt_next = pcnt_reg + 4'd1;
                end
            end else begin
                pcnt_next = PROLOG_DONE;
            end
        end
        pos_next = pos1;
        if (s_tlast) begin
            if (pskip_next) begin
                mode_next = MODE_IDLE;
            end
            case (mode_next)
                MODE_LT:         tb = add_tok(tb, KIND_OPEN, pos1, '0);
                MODE_NAME:       tb = add_tok(tb, pclose_next ? KIND_CLOSE : KIND_OPEN,
                                              pstart_next, pos1 - pstart_next);
                MODE_NAME_SLASH: tb = add_tok(tb, KIND_UNKNOWN, pstart_next, OFF_ONE);
                MODE_SLASH:      tb = add_tok(tb, KIND_UNKNOWN, pstart_next, OFF_ONE);
                MODE_STRING:     tb = add_tok(tb, KIND_STRING, pstart_next,
                                              pos1 - pstart_next);
                default:         tb = tb;
            endcase
            tb          = add_tok(tb, KIND_EOS, pos1, OFF_ONE);
            mode_next   = MODE_IDLE;
            pos_next    = '0;
            pstart_next = '0;
            pclose_next = 1'b0;
            pcnt_next   = '0;
            pskip_next  = 1'b0;
        end
    end

    assign s_tready = count_reg <= CNT_W'(FIFO_DEPTH - MAX_TOK);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = count_reg != '0;
    assign pop      = m_tvalid && m_tready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (accept) begin
            wr_ptr_next = wr_ptr_reg + PTR_W'(tb.n);
            count_next  = count_next + CNT_W'(tb.n);
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + PTR_W'(1);
            count_next  = count_next - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_IDLE;
            pos_reg    <= '0;
            pstart_reg <= '0;
            pclose_reg <= 1'b0;
            pcnt_reg   <= '0;
            pskip_reg  <= 1'b0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (accept) begin
                mode_reg   <= mode_next;
                pos_reg    <= pos_next;
                pstart_reg <= pstart_next;
                pclose_reg <= pclose_next;
                pcnt_reg   <= pcnt_next;
                pskip_reg  <= pskip_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_TOK; i++) begin
            if (accept && 2'(i) < tb.n) begin
                fifo_reg[wr_ptr_reg + PTR_W'(i)] <= '{last: (2'(i + 1) == tb.n),
                                                      tok: tb.t[i]};
            end
        end
    end

    assign m_tdata = {{(TDATA_OUT_W - $bits(token_t)){1'b0}}, fifo_reg[rd_ptr_reg].tok};
    assign m_tlast = fifo_reg[rd_ptr_reg].last;

endmodule

FILE: design/mtt_checker.sv
module mtt_checker import mtt_pkg::*; (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic [TDATA_IN_W-1:0]  s_tdata,
    input logic                   s_tlast,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [TDATA_OUT_W-1:0] m_tdata,
    input logic                   m_tlast
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    a_kind_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[2:0] <= 3'(KIND_EOS))
        else $error("token kind out of range");

    a_single_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[2:0] == 3'(KIND_EQUALS) || m_tdata[2:0] == 3'(KIND_UNKNOWN) ||
                     m_tdata[2:0] == 3'(KIND_EOS))
        |-> m_tdata[66:35] == 32'd1)
        else $error("single-character token with length other than one");

    a_final_eos: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> m_tvalid)
        else $error("no token after final byte");

endmodule

bind markup_tag_tokenizer_top mtt_checker u_mtt_checker (.*);

FILE: verif/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mtt_pkg::*;

    localparam int          HOLD_CYCLES = 300;
    localparam int          MAX_REPORTS = 40;
    localparam logic [3:0]  DOCTYPE_LEN = 4'd9;
    localparam logic [3:0]  MATCH_OFF   = 4'hF;
    localparam logic [7:0]  CH_A        = "a";
    localparam logic [0:8][7:0] DOCTYPE_TAG = "<!DOCTYPE";
    localparam logic [0:5][7:0] BLANKS   = {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
    localparam logic [0:5][7:0] SPECIALS = {CH_NUL, CH_LT, CH_GT, CH_SLASH, CH_EQ, CH_QUOTE};

    typedef struct packed {
        logic [7:0] b;
        logic       fin;
    } doc_byte_t;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [TDATA_IN_W-1:0]  s_tdata  = '0;
    logic                   s_tlast  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [TDATA_OUT_W-1:0] m_tdata;
    logic                   m_tlast;

    doc_byte_t  doc_q[$];
    logic [7:0] doc_bytes[$];
    entry_t     token_q[$];
    entry_t     step_toks[$];

    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   err_count      = 0;
    logic s_fire         = 1'b0;
    logic hold_go        = 1'b0;
    logic holding        = 1'b0;

    mode_t      scan_st    = MODE_IDLE;
    off_t       byte_pos   = '0;
    off_t       tok_start  = '0;
    logic       tok_close  = 1'b0;
    logic [3:0] prolog_cnt = '0;
    logic       in_prolog  = 1'b0;

    markup_tag_tokenizer_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    task automatic report_error(string msg);
        if (err_count < MAX_REPORTS) begin
            $display("ERROR @%0t: %s", $realtime, msg);
        end
        err_count++;
    endtask

    function automatic logic is_blank(logic [7:0] b);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < 6; i++) begin
            if (b == BLANKS[i]) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    task automatic clear_scan();
        scan_st    = MODE_IDLE;
        byte_pos   = '0;
        tok_start  = '0;
        tok_close  = 1'b0;
        prolog_cnt = '0;
        in_prolog  = 1'b0;
    endtask

    task automatic add_token(kind_t k, off_t start, off_t len);
        entry_t e;
        if (step_toks.size() < MAX_TOK) begin
            e.last      = 1'b0;
            e.tok.kind  = k;
            e.tok.start = start;
            e.tok.len   = len;
            step_toks.push_back(e);
        end
    endtask

    task automatic add_tag(off_t stop);
        if (tok_close) begin
            add_token(KIND_CLOSE, tok_start, stop - tok_start);
        end else begin
            add_token(KIND_OPEN, tok_start, stop - tok_start);
        end
    endtask

    task automatic scan_markup_byte(logic [7:0] b, off_t pos);
        logic done;
        done = 1'b0;
        for (int pass = 0; pass < 3 && !done; pass++) begin
            done = 1'b1;
            case (scan_st)
                MODE_LT: begin
                    scan_st = MODE_NAME;
                    if (b == CH_SLASH) begin
                        tok_close = 1'b1;
                        tok_start = pos + OFF_ONE;
                    end else begin
                        tok_close = 1'b0;
                        tok_start = pos;
                        done      = 1'b0;
                    end
                end
                MODE_NAME: begin
                    if (is_blank(b) || b == CH_GT) begin
                        add_tag(pos);
                        scan_st = MODE_IDLE;
                    end else if (b == CH_SLASH) begin
                        add_tag(pos);
                        tok_start = pos;
                        scan_st   = MODE_NAME_SLASH;
                    end
                end
                MODE_NAME_SLASH: begin
                    scan_st = MODE_IDLE;
                    if (b != CH_GT) begin
                        add_token(KIND_UNKNOWN, tok_start, OFF_ONE);
                        done = 1'b0;
                    end
                end
                MODE_SLASH: begin
                    scan_st = MODE_IDLE;
                    if (b == CH_GT) begin
                        add_token(KIND_CLOSE, tok_start, OFF_ONE);
                    end else begin
                        add_token(KIND_UNKNOWN, tok_start, OFF_ONE);
                        done = 1'b0;
                    end
                end
                MODE_STRING: begin
                    if (b == CH_QUOTE || b == CH_NUL || b == CH_EQ || b == CH_LT) begin
                        add_token(KIND_STRING, tok_start, pos - tok_start);
                        scan_st = MODE_IDLE;
                        done    = (b == CH_QUOTE);
                    end
                end
                default: begin
                    scan_st = MODE_IDLE;
                    if (is_blank(b)) begin
                    end else if (b == CH_NUL) begin
                        add_token(KIND_EOS, pos, OFF_ONE);
                    end else if (b == CH_EQ) begin
                        add_token(KIND_EQUALS, pos, OFF_ONE);
                    end else if (b == CH_LT) begin
                        tok_start = pos;
                        scan_st   = MODE_LT;
                    end else if (b == CH_SLASH) begin
                        tok_start = pos;
                        scan_st   = MODE_SLASH;
                    end else begin
                        tok_start = (b == CH_QUOTE) ? pos + OFF_ONE : pos;
                        scan_st   = MODE_STRING;
                    end
                end
            endcase
        end
    endtask

    task automatic flush_document(off_t stop);
        case (scan_st)
            MODE_LT:                     add_token(KIND_OPEN, stop, '0);
            MODE_NAME:                   add_tag(stop);
            MODE_NAME_SLASH, MODE_SLASH: add_token(KIND_UNKNOWN, tok_start, OFF_ONE);
            MODE_STRING:                 add_token(KIND_STRING, tok_start, stop - tok_start);
            default: begin
            end
        endcase
        add_token(KIND_EOS, stop, OFF_ONE);
    endtask

    task automatic predict_tokens(logic [7:0] b, logic fin);
        off_t pos;
        pos = byte_pos;
        step_toks.delete();
        if (in_prolog) begin
            if (b == CH_NUL || b == CH_LT) begin
                in_prolog = 1'b0;
                scan_st   = MODE_IDLE;
                scan_markup_byte(b, pos);
            end
        end else begin
            scan_markup_byte(b, pos);
            if (prolog_cnt < DOCTYPE_LEN) begin
                if (b == DOCTYPE_TAG[prolog_cnt]) begin
                    prolog_cnt = prolog_cnt + 4'd1;
                    if (prolog_cnt == DOCTYPE_LEN) begin
                        prolog_cnt = MATCH_OFF;
                        in_prolog  = 1'b1;
                        scan_st    = MODE_IDLE;
                    end
                end else begin
                    prolog_cnt = MATCH_OFF;
                end
            end
        end
        byte_pos = pos + OFF_ONE;
        if (fin) begin
            if (in_prolog) begin
                scan_st = MODE_IDLE;
            end
            flush_document(byte_pos);
            clear_scan();
        end
        if (step_toks.size() != 0) begin
            step_toks[step_toks.size() - 1].last = 1'b1;
        end
        foreach (step_toks[i]) begin
            token_q.push_back(step_toks[i]);
        end
    endtask

    task automatic add_str(string s);
        for (int i = 0; i < s.len(); i++) begin
            doc_bytes.push_back(s[i]);
        end
    endtask

    task automatic add_name();
        repeat ($urandom_range(1, 4)) begin
            doc_bytes.push_back(CH_A + 8'($urandom_range(0, 25)));
        end
    endtask

    task automatic add_blank();
        doc_bytes.push_back(BLANKS[$urandom_range(0, 5)]);
    endtask

    task automatic add_quoted();
        add_str("\"");
        add_name();
        if ($urandom_range(0, 2) == 0) begin
            add_blank();
            add_name();
        end
        add_str("\"");
    endtask

    task automatic add_noise();
        if ($urandom_range(0, 3) == 0) begin
            doc_bytes.push_back(SPECIALS[$urandom_range(0, 5)]);
        end else begin
            doc_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic commit_doc();
        doc_byte_t db;
        foreach (doc_bytes[i]) begin
            db.b   = doc_bytes[i];
            db.fin = (i == doc_bytes.size() - 1);
            doc_q.push_back(db);
        end
    endtask

    task automatic push_doc(string s);
        doc_bytes.delete();
        add_str(s);
        commit_doc();
    endtask

    task automatic gen_doc();
        doc_bytes.delete();
        case ($urandom_range(0, 7))
            0: begin
                add_str("<!DOCTYPE");
                add_blank();
                add_name();
            end
            1: add_str("<!DOC");
            default: begin
            end
        endcase
        repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    add_str("<");
                    add_name();
                    repeat ($urandom_range(0, 2)) begin
                        add_blank();
                        add_name();
                        if ($urandom_range(0, 2) != 0) begin
                            add_str("=");
                            if ($urandom_range(0, 1) == 1) begin
                                add_quoted();
                            end else begin
                                add_name();
                            end
                        end
                    end
                    case ($urandom_range(0, 3))
                        0: add_str("/>");
                        1: begin
                            add_blank();
                            add_str(">");
                        end
                        default: add_str(">");
                    endcase
                end
                2: begin
                    add_str("</");
                    add_name();
                    add_str(">");
                end
                3: add_blank();
                4: begin
                    add_name();
                    add_blank();
                    add_name();
                end
                5: begin
                    repeat ($urandom_range(1, 3)) begin
                        add_noise();
                    end
                end
                6: begin
                    add_str("/");
                    add_noise();
                end
                7: add_str("=");
                8: add_quoted();
                default: begin
                    if ($urandom_range(0, 1) == 1) begin
                        add_str("</>");
                    end else begin
                        add_str("<>");
                    end
                end
            endcase
        end
        case ($urandom_range(0, 5))
            0: add_str("<");
            1: add_str("/");
            2: add_str("<a");
            3: add_noise();
            default: begin
            end
        endcase
        commit_doc();
    endtask

    task automatic wait_drained();
        while (doc_q.size() != 0 || token_q.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic run_phase(int idle_pct, int stall_pct, int n_bytes);
        int queued;
        queued         = 0;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        while (queued < n_bytes) begin
            gen_doc();
            queued += doc_bytes.size();
        end
        wait_drained();
    endtask

    // driver: hold the offered byte until its transfer, then advance
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_fire) begin
            if (doc_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= doc_q[0].b;
                s_tlast  <= doc_q[0].fin;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        m_tready <= !holding && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    initial begin
        wait (hold_go);
        @(negedge aclk);
        holding <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge aclk);
        holding <= 1'b0;
    end

    always @(posedge aclk) begin
        entry_t want;
        if (!aresetn) begin
            s_fire <= 1'b0;
            clear_scan();
            token_q.delete();
        end else begin
            s_fire <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                predict_tokens(s_tdata, s_tlast);
                doc_q.delete(0);
            end
            if (m_tvalid && m_tready) begin
                if (token_q.size() == 0) begin
                    report_error($sformatf("unexpected token, tdata %h", m_tdata));
                end else begin
                    want = token_q.pop_front();
                    if (m_tdata[2:0] != want.tok.kind || m_tdata[34:3] != want.tok.start ||
                        m_tdata[66:35] != want.tok.len || m_tlast != want.last) begin
                        report_error($sformatf(
                            "token: kind %0d/%0d start %0d/%0d len %0d/%0d last %0b/%0b",
                            m_tdata[2:0], want.tok.kind, m_tdata[34:3], want.tok.start,
                            m_tdata[66:35], want.tok.len, m_tlast, want.last));
                    end
                end
            end
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        push_doc("<!DOCTYPE");
        push_doc("<a/x\"q\"=/>/y</");
        doc_bytes.delete();
        doc_bytes.push_back(8'hFF);
        doc_bytes.push_back(CH_NUL);
        doc_bytes.push_back(CH_LT);
        commit_doc();
        wait_drained();

        run_phase(0, 0, 35);
        run_phase(88, 0, 35);
        run_phase(0, 88, 35);
        run_phase(17, 17, 35);
        hold_go = 1'b1;
        run_phase(0, 0, 35);

        repeat (20) @(posedge aclk);
        if (err_count == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
